[hdl/auto_contrast_16_to_8_top_defines.svh]
// assertion macros shared by the auto contrast checker
// no dependencies; included by acs_chk.sv
`ifndef AUTO_CONTRAST_16_TO_8_TOP_DEFINES_SVH
`define AUTO_CONTRAST_16_TO_8_TOP_DEFINES_SVH

// checked property, skipped while reset is low
`define ACS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also evaluated during reset
`define ACS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/acs_pkg.sv]
// shared widths, codes and control structs for the auto contrast block
// no dependencies; imported by every module of the block
package acs_pkg;

  localparam int PIX_W      = 16;
  localparam int LVL_W      = 8;
  localparam int NUM_W      = PIX_W + LVL_W;
  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int MWIN_W     = 5;
  localparam int WIN_CMP_W  = (CNT_W > MWIN_W) ? CNT_W : MWIN_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(LVL_W);

  localparam logic [LVL_W-1:0] LEVEL_MAX = '1;
  localparam logic [LVL_W-1:0] LEVEL_MIN = '0;
  localparam logic [PIX_W-1:0] PIX_MAX   = '1;
  localparam logic [PIX_W-1:0] PIX_MIN   = '0;

  localparam logic OP_SCAN    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [PIX_W-1:0]  FIXED_LOW_RST  = '0;
  localparam logic [PIX_W-1:0]  FIXED_HIGH_RST = '1;
  localparam logic [MWIN_W-1:0] MED_WIN_RST    = MWIN_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_MODE,
    CFG_FIXED_LOW,
    CFG_FIXED_HIGH,
    CFG_MEDIAN_WINDOW
  } acs_cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [PIX_W-1:0] push_min;
    logic [PIX_W-1:0] push_max;
    logic [CNT_W-1:0] win;
  } acs_med_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] low;
    logic [PIX_W-1:0] high;
  } acs_med_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [PIX_W-1:0] den;
  } acs_div_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] quo;
  } acs_div_rsp_t;

endpackage

[hdl/acs_med.sv]
// history of frame extremes and median selection by rank counting
// depends on acs_pkg
module acs_med (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acs_pkg::acs_med_req_t med_req,
  output acs_pkg::acs_med_rsp_t med_rsp
);
  import acs_pkg::*;

  typedef enum logic {M_IDLE, M_RUN} med_state_t;

  logic [PIX_W-1:0] min_mem [MAX_WINDOW];
  logic [PIX_W-1:0] max_mem [MAX_WINDOW];

  med_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] newest_r, newest_nxt;
  logic [CNT_W-1:0] ci_r, ci_nxt;
  logic [CNT_W-1:0] cj_r, cj_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic             row_end_r, row_end_nxt;
  logic             all_end_r, all_end_nxt;
  logic [CNT_W-1:0] lt_lo_r, lt_lo_nxt, le_lo_r, le_lo_nxt;
  logic [CNT_W-1:0] lt_hi_r, lt_hi_nxt, le_hi_r, le_hi_nxt;
  logic [PIX_W-1:0] med_lo_r, med_lo_nxt, med_hi_r, med_hi_nxt;
  logic             done_r, done_nxt;
  logic [PIX_W-1:0] rd_a_min_r, rd_b_min_r, rd_a_max_r, rd_b_max_r;

  logic [SLOT_W-1:0] addr_a, addr_b;
  logic [CNT_W:0]    cnt_inc;
  logic [CNT_W-1:0]  cnt_last, half;
  logic [CNT_W-1:0]  lt_lo_inc, le_lo_inc, lt_hi_inc, le_hi_inc;
  logic              row_end_now;

  function automatic logic [SLOT_W-1:0] hist_idx(input logic [SLOT_W-1:0] newest,
                                                 input logic [CNT_W-1:0] k);
    logic [SLOT_W:0] n_e;
    logic [SLOT_W:0] k_e;
    n_e = {1'b0, newest};
    k_e = (SLOT_W+1)'(k);
    if (k_e > n_e) begin
      return SLOT_W'(n_e + (SLOT_W+1)'(MAX_WINDOW) - k_e);
    end
    return SLOT_W'(n_e - k_e);
  endfunction

  assign addr_a   = hist_idx(newest_r, ci_r);
  assign addr_b   = hist_idx(newest_r, cj_r);
  assign cnt_inc  = (CNT_W+1)'(count_r) + (CNT_W+1)'(1);
  assign cnt_last = count_r - CNT_W'(1);
  assign half     = count_r >> 1;
  assign row_end_now = (cj_r == cnt_last);

  assign lt_lo_inc = lt_lo_r + CNT_W'(rd_b_min_r <  rd_a_min_r);
  assign le_lo_inc = le_lo_r + CNT_W'(rd_b_min_r <= rd_a_min_r);
  assign lt_hi_inc = lt_hi_r + CNT_W'(rd_b_max_r <  rd_a_max_r);
  assign le_hi_inc = le_hi_r + CNT_W'(rd_b_max_r <= rd_a_max_r);

  always_ff @(posedge clk) begin
    if (med_req.start) begin
      min_mem[slot_r] <= med_req.push_min;
      max_mem[slot_r] <= med_req.push_max;
    end
    rd_a_min_r <= min_mem[addr_a];
    rd_b_min_r <= min_mem[addr_b];
    rd_a_max_r <= max_mem[addr_a];
    rd_b_max_r <= max_mem[addr_b];
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    slot_nxt    = slot_r;
    newest_nxt  = newest_r;
    ci_nxt      = ci_r;
    cj_nxt      = cj_r;
    cmp_v_nxt   = 1'b0;
    row_end_nxt = 1'b0;
    all_end_nxt = 1'b0;
    lt_lo_nxt   = lt_lo_r;
    le_lo_nxt   = le_lo_r;
    lt_hi_nxt   = lt_hi_r;
    le_hi_nxt   = le_hi_r;
    med_lo_nxt  = med_lo_r;
    med_hi_nxt  = med_hi_r;
    done_nxt    = cmp_v_r & all_end_r;

    case (state_r)
      M_IDLE: begin
        if (med_req.start) begin
          if (cnt_inc > (CNT_W+1)'(med_req.win)) begin
            count_nxt = med_req.win;
          end else begin
            count_nxt = CNT_W'(cnt_inc);
          end
          newest_nxt = slot_r;
          slot_nxt   = (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
          ci_nxt     = '0;
          cj_nxt     = '0;
          state_nxt  = M_RUN;
        end
      end
      M_RUN: begin
        cmp_v_nxt   = 1'b1;
        row_end_nxt = row_end_now;
        all_end_nxt = row_end_now && (ci_r == cnt_last);
        if (row_end_now) begin
          cj_nxt = '0;
          ci_nxt = ci_r + CNT_W'(1);
        end else begin
          cj_nxt = cj_r + CNT_W'(1);
        end
        if (all_end_nxt) begin
          state_nxt = M_IDLE;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase

    // rank test on the word read in the previous cycle
    if (cmp_v_r) begin
      if (row_end_r) begin
        if (lt_lo_inc <= half && le_lo_inc > half) begin
          med_lo_nxt = rd_a_min_r;
        end
        if (lt_hi_inc <= half && le_hi_inc > half) begin
          med_hi_nxt = rd_a_max_r;
        end
        lt_lo_nxt = '0;
        le_lo_nxt = '0;
        lt_hi_nxt = '0;
        le_hi_nxt = '0;
      end else begin
        lt_lo_nxt = lt_lo_inc;
        le_lo_nxt = le_lo_inc;
        lt_hi_nxt = lt_hi_inc;
        le_hi_nxt = le_hi_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= M_IDLE;
      count_r   <= '0;
      slot_r    <= '0;
      newest_r  <= '0;
      ci_r      <= '0;
      cj_r      <= '0;
      cmp_v_r   <= 1'b0;
      row_end_r <= 1'b0;
      all_end_r <= 1'b0;
      lt_lo_r   <= '0;
      le_lo_r   <= '0;
      lt_hi_r   <= '0;
      le_hi_r   <= '0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      slot_r    <= slot_nxt;
      newest_r  <= newest_nxt;
      ci_r      <= ci_nxt;
      cj_r      <= cj_nxt;
      cmp_v_r   <= cmp_v_nxt;
      row_end_r <= row_end_nxt;
      all_end_r <= all_end_nxt;
      lt_lo_r   <= lt_lo_nxt;
      le_lo_r   <= le_lo_nxt;
      lt_hi_r   <= lt_hi_nxt;
      le_hi_r   <= le_hi_nxt;
      done_r    <= done_nxt;
    end
    med_lo_r <= med_lo_nxt;
    med_hi_r <= med_hi_nxt;
  end

  assign med_rsp.done = done_r;
  assign med_rsp.low  = med_lo_r;
  assign med_rsp.high = med_hi_r;

endmodule

[hdl/acs_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on acs_pkg
module acs_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acs_pkg::acs_div_req_t div_req,
  output acs_pkg::acs_div_rsp_t div_rsp
);
  import acs_pkg::*;

  logic [PIX_W-1:0]     rem_r, rem_nxt;
  logic [LVL_W-1:0]     sh_r, sh_nxt;
  logic [PIX_W-1:0]     den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [PIX_W:0]   cat;
  logic [PIX_W+1:0] diff;

  assign cat  = {rem_r, sh_r[LVL_W-1]};
  assign diff = {1'b0, cat} - {2'b00, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (div_req.start) begin
      // numerator high part is already below the divisor
      rem_nxt  = div_req.num[NUM_W-1:LVL_W];
      sh_nxt   = div_req.num[LVL_W-1:0];
      den_nxt  = div_req.den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[PIX_W+1]) begin
        rem_nxt = diff[PIX_W-1:0];
        sh_nxt  = {sh_r[LVL_W-2:0], 1'b1};
      end else begin
        rem_nxt = cat[PIX_W-1:0];
        sh_nxt  = {sh_r[LVL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(LVL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign div_rsp.done = done_r;
  assign div_rsp.quo  = sh_r;

endmodule

[hdl/auto_contrast_16_to_8_top.sv]
// auto contrast 16 to 8: min/max tracking, median smoothing, serial rescale
// depends on acs_pkg, acs_med, acs_div
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_op, in_pixel, in_last
//   out      out_valid/out_ready  out_level, out_frame_end
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// scan word: input stays open, but last word with smoothing waits for median of n words
// convert word: 8-step serial divider plus setup, start and output;
// setup goes straight to output when the range is empty or the pixel is at or beyond a bound
// median search compares history words one pair per cycle through registered reads
// synchronous active-low reset; history memory has no clearing pass
// a finished word waits in the output register while the next word is accepted
module auto_contrast_16_to_8_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [acs_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acs_pkg::LVL_W-1:0]     out_level,
  output logic                          out_frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import acs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MED, S_PREP, S_MUL, S_DIV, S_OUT} acs_state_t;

  acs_state_t        state_r, state_nxt;
  logic              auto_mode_r;
  logic [PIX_W-1:0]  fixed_low_r, fixed_high_r;
  logic [MWIN_W-1:0] med_win_r;
  logic [PIX_W-1:0]  run_min_r, run_min_nxt, run_max_r, run_max_nxt;
  logic [PIX_W-1:0]  bound_lo_r, bound_lo_nxt, bound_hi_r, bound_hi_nxt;
  logic [PIX_W-1:0]  px_r, px_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic              last_r, last_nxt;
  logic [PIX_W-1:0]  sub_r, sub_nxt, den_r, den_nxt;
  logic [LVL_W-1:0]  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LVL_W-1:0]  out_level_r, out_level_nxt;
  logic              out_fe_r, out_fe_nxt;

  logic                 in_acc;
  logic [PIX_W-1:0]     scan_min, scan_max;
  logic [WIN_CMP_W-1:0] win_ext;
  logic [CNT_W-1:0]     win_c;
  logic                 smooth;
  acs_med_req_t         med_req;
  acs_med_rsp_t         med_rsp;
  acs_div_req_t         div_req;
  acs_div_rsp_t         div_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;

  assign scan_min = (in_pixel < run_min_r) ? in_pixel : run_min_r;
  assign scan_max = (in_pixel > run_max_r) ? in_pixel : run_max_r;
  assign win_ext  = WIN_CMP_W'(med_win_r);
  assign win_c    = (win_ext > WIN_CMP_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(win_ext);
  assign smooth   = (win_c > CNT_W'(1));

  assign med_req.start    = in_acc & (in_op == OP_SCAN) & in_last & auto_mode_r & smooth;
  assign med_req.push_min = scan_min;
  assign med_req.push_max = scan_max;
  assign med_req.win      = win_c;

  // sub * 255 as sub * 256 - sub
  assign div_req.start = (state_r == S_MUL);
  assign div_req.num   = {sub_r, {LVL_W{1'b0}}} - NUM_W'(sub_r);
  assign div_req.den   = den_r;

  acs_med u_med (
    .clk     (clk),
    .rst_n   (rst_n),
    .med_req (med_req),
    .med_rsp (med_rsp)
  );

  acs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    run_min_nxt   = run_min_r;
    run_max_nxt   = run_max_r;
    bound_lo_nxt  = bound_lo_r;
    bound_hi_nxt  = bound_hi_r;
    px_nxt        = px_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    last_nxt      = last_r;
    sub_nxt       = sub_r;
    den_nxt       = den_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_level_nxt = out_level_r;
    out_fe_nxt    = out_fe_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_SCAN) begin
            run_min_nxt = scan_min;
            run_max_nxt = scan_max;
            if (in_last) begin
              run_min_nxt = PIX_MAX;
              run_max_nxt = PIX_MIN;
              if (auto_mode_r) begin
                if (smooth) begin
                  state_nxt = S_MED;
                end else begin
                  bound_lo_nxt = scan_min;
                  bound_hi_nxt = scan_max;
                end
              end
            end
          end else begin
            px_nxt    = in_pixel;
            lo_nxt    = auto_mode_r ? bound_lo_r : fixed_low_r;
            hi_nxt    = auto_mode_r ? bound_hi_r : fixed_high_r;
            last_nxt  = in_last;
            state_nxt = S_PREP;
          end
        end
      end
      S_MED: begin
        if (med_rsp.done) begin
          bound_lo_nxt = med_rsp.low;
          bound_hi_nxt = med_rsp.high;
          state_nxt    = S_IDLE;
        end
      end
      S_PREP: begin
        sub_nxt = px_r - lo_r;
        den_nxt = hi_r - lo_r;
        if (hi_r <= lo_r || px_r <= lo_r) begin
          res_nxt   = LEVEL_MIN;
          state_nxt = S_OUT;
        end else if (px_r >= hi_r) begin
          res_nxt   = LEVEL_MAX;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = res_r;
          out_fe_nxt    = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      auto_mode_r  <= 1'b1;
      fixed_low_r  <= FIXED_LOW_RST;
      fixed_high_r <= FIXED_HIGH_RST;
      med_win_r    <= MED_WIN_RST;
      run_min_r    <= PIX_MAX;
      run_max_r    <= PIX_MIN;
      bound_lo_r   <= PIX_MIN;
      bound_hi_r   <= PIX_MIN;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_min_r   <= run_min_nxt;
      run_max_r   <= run_max_nxt;
      bound_lo_r  <= bound_lo_nxt;
      bound_hi_r  <= bound_hi_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AUTO_MODE:     auto_mode_r  <= cfg_data[0];
          CFG_FIXED_LOW:     fixed_low_r  <= cfg_data[PIX_W-1:0];
          CFG_FIXED_HIGH:    fixed_high_r <= cfg_data[PIX_W-1:0];
          CFG_MEDIAN_WINDOW: med_win_r    <= cfg_data[MWIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
    px_r        <= px_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    last_r      <= last_nxt;
    sub_r       <= sub_nxt;
    den_r       <= den_nxt;
    res_r       <= res_nxt;
    out_level_r <= out_level_nxt;
    out_fe_r    <= out_fe_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_level_r;
  assign out_frame_end = out_fe_r;

endmodule

[hdl/acs_chk.sv]
// port-level checks for the auto contrast top level, attached by bind
// depends on auto_contrast_16_to_8_top_defines.svh and acs_pkg
`include "auto_contrast_16_to_8_top_defines.svh"
module acs_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_op,
  input logic                      in_last,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [acs_pkg::LVL_W-1:0] out_level,
  input logic                      out_frame_end
);
  import acs_pkg::*;

  // output word holds while stalled
  `ACS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_frame_end), "output word changed while stalled")

  // a convert word keeps the input closed for its setup cycle
  `ACS_ASSERT(a_conv_busy, in_valid && in_ready && in_op == OP_CONVERT |=> !in_ready, "input open right after convert word")

  // a scan word that does not end the frame leaves the input open in the next cycle
  `ACS_ASSERT(a_scan_fast, in_valid && in_ready && in_op == OP_SCAN && !in_last |=> in_ready, "input closed after plain scan word")

  // reset empties the output register
  `ACS_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind auto_contrast_16_to_8_top acs_chk u_acs_chk (.*);
